// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DRV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DRV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/drv_pkg.sv =====
// Types and constants of the difficulty retarget verifier.
`default_nettype none
package drv_pkg;

  localparam int TARGET_SPAN     = 14 * 24 * 60 * 60;
  localparam int SPAN_MIN        = TARGET_SPAN / 4;
  localparam int SPAN_MAX        = TARGET_SPAN * 4;
  localparam int SPAN_DIV        = TARGET_SPAN / 256;
  localparam logic [31:0] POW_LIMIT_RESET = 32'h1d00_ffff;

  localparam int MANT_W    = 24;
  localparam int SPAN_W    = 23;
  localparam int DVD_W     = 48;
  localparam int DVS_W     = 16;
  localparam int DIV_DIGITS = DVD_W / 4;
  localparam int CNT_W     = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_NORM,
    ST_EMIT
  } drv_state_e;

  typedef struct packed {
    logic load_in;   // capture input beat, start height modulo
    logic div_step;  // one radix-16 digit of the shared divider
    logic decide;    // early verdict without retarget
    logic mul;       // mantissa times span into the divider
    logic norm;      // verdict from recomputed target
    logic emit;      // move verdict into output register
  } drv_cmd_t;

  typedef struct packed {
    logic need_rt;   // retarget path must run
    logic out_free;  // output register can take a beat
  } drv_sts_t;

endpackage
`default_nettype wire

// ===== design/drv_div.sv =====
// Shared radix-16 restoring divider, one quotient digit per cycle while step_i is high.
`default_nettype none
module drv_div (
  input  wire logic                      clk_i,
  input  wire logic                      load_i,
  input  wire logic                      step_i,
  input  wire logic [drv_pkg::DVD_W-1:0] dividend_i,
  input  wire logic [drv_pkg::DVS_W-1:0] divisor_i,
  output logic      [drv_pkg::DVD_W-1:0] quotient_o,
  output logic      [drv_pkg::DVS_W-1:0] rem_o
);
  import drv_pkg::*;

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W+3:0] part;
  logic [3:0]       qd;

  // dividend shifts out at the top, quotient digits shift in at the bottom
  always_comb begin
    part = {rem_q, dvd_q[DVD_W-1 -: 4]};
    for (int k = 3; k >= 0; k--) begin
      if (part >= ({4'b0, dvs_q} << k)) begin
        part  = part - ({4'b0, dvs_q} << k);
        qd[k] = 1'b1;
      end else begin
        qd[k] = 1'b0;
      end
    end
    rem_d = part[DVS_W-1:0];
    dvd_d = {dvd_q[DVD_W-5:0], qd};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (step_i) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = dvd_q;
  assign rem_o      = rem_q;

endmodule
`default_nettype wire

// ===== design/drv_datapath.sv =====
// Datapath: input capture, span clamp, multiply, normalize, verdict, output.
`default_nettype none
module drv_datapath #(
  parameter int RETARGET_INTERVAL = 2016
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire drv_pkg::drv_cmd_t cmd_i,
  output drv_pkg::drv_sts_t      sts_o,
  input  wire logic              cfg_we_i,
  input  wire logic [31:0]       cfg_wdata_i,
  input  wire logic              hash_link_ok_i,
  input  wire logic [31:0]       block_height_i,
  input  wire logic [31:0]       block_target_i,
  input  wire logic [31:0]       prev_height_i,
  input  wire logic [31:0]       prev_target_i,
  input  wire logic [31:0]       prev_timestamp_i,
  input  wire logic [31:0]       transition_time_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   valid_res_o
);
  import drv_pkg::*;

  logic [31:0]       pow_limit_q;
  logic              link_q;
  logic [31:0]       height_q, target_q, prev_h_q, prev_t_q, trans_q;
  logic [SPAN_W-1:0] span_q, span_d;
  logic              ok_q, ok_early;
  logic              out_valid_q, valid_res_q;

  logic signed [32:0]       diff;
  logic [MANT_W+SPAN_W-1:0] prod;
  logic [DVD_W-1:0]         dividend, quotient;
  logic [DVS_W-1:0]         divisor, rem;
  logic                     link_ok, at_rt;

  logic [34:0] q;
  logic [7:0]  e, lim_e;
  logic [1:0]  k_m, k_e, k;
  logic [8:0]  size;
  logic [22:0] mant_n;
  logic        over;
  logic [31:0] new_target;

  // timespan clamp, signed so that a transition after the predecessor clamps low
  always_comb begin
    diff = $signed({1'b0, prev_timestamp_i}) - $signed({1'b0, transition_time_i});
    if (diff < $signed(33'(SPAN_MIN))) begin
      span_d = SPAN_W'(SPAN_MIN);
    end else if (diff > $signed(33'(SPAN_MAX))) begin
      span_d = SPAN_W'(SPAN_MAX);
    end else begin
      span_d = diff[SPAN_W-1:0];
    end
  end

  assign prod     = prev_t_q[MANT_W-1:0] * span_q;
  assign dividend = cmd_i.mul ? {{(DVD_W-MANT_W-SPAN_W){1'b0}}, prod}
                              : {{(DVD_W-32){1'b0}}, block_height_i};
  assign divisor  = cmd_i.mul ? DVS_W'(SPAN_DIV) : DVS_W'(RETARGET_INTERVAL);

  drv_div u_div (
    .clk_i      (clk_i),
    .load_i     (cmd_i.load_in | cmd_i.mul),
    .step_i     (cmd_i.div_step),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quotient_o (quotient),
    .rem_o      (rem)
  );

  always_comb begin
    link_ok = link_q && (height_q == prev_h_q + 32'd1);
    at_rt   = (rem == '0);
    if (!link_ok) begin
      ok_early = 1'b0;
    end else if (!at_rt) begin
      ok_early = (target_q == prev_t_q);
    end else begin
      ok_early = 1'b0;
    end
  end

  assign sts_o.need_rt  = link_ok && at_rt && (trans_q != '0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // renormalize: at most two byte shifts, from exponent floor or mantissa size
  always_comb begin
    q     = quotient[34:0];
    e     = prev_t_q[31:24];
    lim_e = pow_limit_q[31:24];
    if (q[34:31] != '0) begin
      k_m = 2'd2;
    end else if (q[30:23] != '0) begin
      k_m = 2'd1;
    end else begin
      k_m = 2'd0;
    end
    if (e == 8'd0) begin
      k_e = 2'd2;
    end else if (e == 8'd1) begin
      k_e = 2'd1;
    end else begin
      k_e = 2'd0;
    end
    k    = (k_m > k_e) ? k_m : k_e;
    size = {1'b0, e} + {7'b0, k} - 9'd1;
    case (k)
      2'd0:    mant_n = q[22:0];
      2'd1:    mant_n = q[30:8];
      default: mant_n = {4'b0, q[34:16]};
    endcase
    over = (size > {1'b0, lim_e}) ||
           ((size == {1'b0, lim_e}) && ({1'b0, mant_n} > pow_limit_q[23:0]));
    new_target = over ? pow_limit_q : {size[7:0], 1'b0, mant_n};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pow_limit_q <= POW_LIMIT_RESET;
    end else if (cfg_we_i) begin
      pow_limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      link_q   <= hash_link_ok_i;
      height_q <= block_height_i;
      target_q <= block_target_i;
      prev_h_q <= prev_height_i;
      prev_t_q <= prev_target_i;
      trans_q  <= transition_time_i;
      span_q   <= span_d;
    end
    if (cmd_i.decide) begin
      ok_q <= ok_early;
    end else if (cmd_i.norm) begin
      ok_q <= (target_q == new_target);
    end
    if (cmd_i.emit) begin
      valid_res_q <= ok_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = valid_res_q;

endmodule
`default_nettype wire

// ===== design/drv_ctrl.sv =====
// Controller: sequences modulo, check, multiply, divide, normalize and emit.
`default_nettype none
module drv_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   busy_o,
  input  wire drv_pkg::drv_sts_t sts_i,
  output drv_pkg::drv_cmd_t      cmd_o
);
  import drv_pkg::*;

  drv_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             last_digit;

  assign last_digit = (cnt_q == CNT_W'(DIV_DIGITS - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_MOD;
      ST_MOD:   if (last_digit) state_d = ST_CHECK;
      ST_CHECK: state_d = sts_i.need_rt ? ST_MUL : ST_EMIT;
      ST_MUL:   state_d = ST_DIV;
      ST_DIV:   if (last_digit) state_d = ST_NORM;
      ST_NORM:  state_d = ST_EMIT;
      ST_EMIT:  if (sts_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cnt_d          = cnt_q;
    busy_o         = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.load_in = in_valid_i;
        cnt_d         = '0;
      end
      ST_MOD, ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
      end
      ST_CHECK: cmd_o.decide = 1'b1;
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
      end
      ST_NORM:  cmd_o.norm = 1'b1;
      ST_EMIT:  cmd_o.emit = sts_i.out_free;
      default:  busy_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/difficulty_retarget_verifier_top.sv =====
// Top level of the difficulty retarget verifier.
//
//   channel  direction  handshake                payload
//   in       sink       in_valid_i / in_stall_o   link, heights, targets, times
//   out      source     out_valid_o / out_stall_i valid_res_o
//   cfg      sink       cfg_we_i                  cfg_wdata_i (pow_limit)
//
// One beat in, one beat out. Every beat runs the height modulo on the shared
// radix-16 divider (12 digits); when the retarget path must run, the divide
// by 4725 follows on the same divider (12 more digits).
// A new beat is taken once the controller is idle; a result waits in the
// output register while the next beat is accepted. Reset clears control and
// loads pow_limit with 0x1d00ffff; no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module difficulty_retarget_verifier_top #(
  parameter int RETARGET_INTERVAL = 2016
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        hash_link_ok_i,
  input  wire logic [31:0] block_height_i,
  input  wire logic [31:0] block_target_i,
  input  wire logic [31:0] prev_height_i,
  input  wire logic [31:0] prev_target_i,
  input  wire logic [31:0] prev_timestamp_i,
  input  wire logic [31:0] transition_time_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             valid_res_o
);
  import drv_pkg::*;

  drv_cmd_t cmd;
  drv_sts_t sts;
  logic     busy;

  drv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .busy_o     (busy),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  drv_datapath #(
    .RETARGET_INTERVAL (RETARGET_INTERVAL)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .hash_link_ok_i    (hash_link_ok_i),
    .block_height_i    (block_height_i),
    .block_target_i    (block_target_i),
    .prev_height_i     (prev_height_i),
    .prev_target_i     (prev_target_i),
    .prev_timestamp_i  (prev_timestamp_i),
    .transition_time_i (transition_time_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .valid_res_o       (valid_res_o)
  );

  assign in_stall_o = busy;

  `DRV_ASSERT_NXT(a_busy_after_beat, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input beat did not make the block busy")
  `DRV_ASSERT_IMP(a_emit_into_free, clk_i, rst_ni, cmd.emit, !out_valid_o || !out_stall_i, "result emitted over a stalled beat")
  `DRV_ASSERT_IMP(a_out_from_emit, clk_i, rst_ni, $rose(out_valid_o), $past(cmd.emit), "output valid rose without emit")

endmodule
`default_nettype wire
